// ----- sv/crrm_pkg.sv -----
`timescale 1ns / 1ps

package crrm_pkg;

  localparam int VALUE_W = 48;
  localparam int STAGE_W = 3;
  localparam int SLOT_W  = 5;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_XLATE = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef struct packed {
    action_t              action;
    logic [STAGE_W-1:0]   stage;
    logic [SLOT_W-1:0]    entry_slot;
    logic [VALUE_W-1:0]   dest_start;
    logic [VALUE_W-1:0]   src_start;
    logic [VALUE_W-1:0]   range_length;
    logic [VALUE_W-1:0]   query_value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   mapped_value;
    logic [VALUE_W-1:0]   lowest_so_far;
    logic                 done_res;
  } rsp_t;

endpackage

// ----- sv/cascaded_range_remap_min_core.sv -----
`timescale 1ns / 1ps

// Cascaded range remap tables with a running minimum.
//
// Request channel (req, req_valid, req_stall): one beat is one command.
// CLEAR drops every table entry and sets the minimum to all ones; LOAD
// writes one entry (stage, entry_slot); TRANSLATE walks query_value
// through all stages in order. Every request gives exactly one response
// beat (rsp, rsp_valid, rsp_stall) with done_res set.
//
// Timing: CLEAR, LOAD and the unused action go straight from accept to the
// finish state. TRANSLATE scans with a single shared compare/add unit fed by
// a registered table memory read, one entry per cycle; an empty stage is left
// without a read, and a stage ends at its first hit or after its last slot.
// The block holds req_stall high for the whole time one request is in work.
//
// Reset clears all entry valid bits and sets the minimum to all ones; no
// memory sweep is needed. A response that the receiver stalls is held in
// the output register; the next request may already be accepted and waits
// to write its response until that beat is taken.
module cascaded_range_remap_min_core
  import crrm_pkg::*;
#(
  parameter int NUM_STAGES        = 7,
  parameter int ENTRIES_PER_STAGE = 32
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic req_valid,
  output logic req_stall,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_stall
);

  // Only stages below 8 and slots below 32 are reachable by a load; the
  // rest are always empty, so they get neither storage nor valid bits.
  localparam int LS   = (NUM_STAGES < (1 << STAGE_W)) ? NUM_STAGES : (1 << STAGE_W);
  localparam int LE   = (ENTRIES_PER_STAGE < (1 << SLOT_W)) ? ENTRIES_PER_STAGE
                                                            : (1 << SLOT_W);
  localparam int DEPTH = LS * LE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ST_W  = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int SL_W  = (LE > 1) ? $clog2(LE) : 1;

  // Entries are stored pre-digested: the match test becomes two compares
  // against [src, lim) and the remap a single add of delta = dest - src.
  typedef struct packed {
    logic [VALUE_W-1:0] delta;
    logic [VALUE_W-1:0] src;
    logic [VALUE_W:0]   lim;
  } map_word_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t             state;
  action_t            op;
  logic [ST_W-1:0]    st;
  logic [SL_W-1:0]    rd_slot;
  logic               rd_live;
  logic [SL_W-1:0]    cmp_slot;
  logic               cmp_live;
  logic [VALUE_W-1:0] cur;
  logic [VALUE_W-1:0] running_min;

  map_word_t          mem [DEPTH];
  map_word_t          rd_word;
  logic [LE-1:0]      valid [LS];
  logic [LE-1:0]      row_valid [NUM_STAGES];

  logic               req_acc;
  logic               rsp_free;
  logic               load_ok;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  map_word_t          wr_word;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               stage_any;
  logic               hit;
  logic               cmp_last;
  logic               stage_done;
  logic               last_stage;
  logic               xlate_done;
  logic               new_min;
  logic [VALUE_W-1:0] fin_mapped;

  // Handshake
  assign req_stall = (state != ST_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Load path: drop loads aimed past the configured table size.
  assign load_ok = ({1'b0, req.stage} < (STAGE_W + 1)'(LS)) &&
                   ({1'b0, req.entry_slot} < (SLOT_W + 1)'(LE));
  assign wr_en   = req_acc && (req.action == ACT_LOAD) && load_ok;
  assign wr_addr = AW'(32'(req.stage) * 32'(LE) + 32'(req.entry_slot));
  assign wr_word.delta = req.dest_start - req.src_start;
  assign wr_word.src   = req.src_start;
  assign wr_word.lim   = {1'b0, req.src_start} + {1'b0, req.range_length};

  // Per-stage occupancy; unreachable stages read as empty.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_row
    if (s < LS) begin : g_live
      assign row_valid[s] = valid[s];
    end else begin : g_empty
      assign row_valid[s] = '0;
    end
  end

  // Scan datapath: one registered read and one compare/add each cycle.
  assign stage_any  = (row_valid[st] != '0);
  assign rd_en      = (state == ST_SCAN) && rd_live && stage_any;
  assign rd_addr    = AW'(32'(st) * 32'(LE) + 32'(rd_slot));
  assign hit        = cmp_live && row_valid[st][cmp_slot] &&
                      (cur >= rd_word.src) && ({1'b0, cur} < rd_word.lim);
  assign cmp_last   = cmp_live && (cmp_slot == SL_W'(LE - 1));
  assign stage_done = !stage_any || hit || cmp_last;
  assign last_stage = (st == ST_W'(NUM_STAGES - 1));
  assign xlate_done = (state == ST_SCAN) && stage_done && last_stage;

  // Result formation
  assign new_min    = (op == ACT_XLATE) && (cur < running_min);
  assign fin_mapped = (op == ACT_XLATE) ? cur : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      op          <= ACT_NOP;
      st          <= '0;
      rd_slot     <= '0;
      rd_live     <= 1'b0;
      cmp_slot    <= '0;
      cmp_live    <= 1'b0;
      running_min <= '1;
      rsp_valid   <= 1'b0;
      for (int s = 0; s < LS; s++) begin
        valid[s] <= '0;
      end
    end else begin
      // Raise valid when the finished beat goes out, drop it once taken.
      if ((state == ST_FINISH) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req_acc) begin
            op       <= req.action;
            st       <= '0;
            rd_slot  <= '0;
            rd_live  <= 1'b1;
            cmp_live <= 1'b0;
            unique case (req.action)
              ACT_CLEAR: begin
                running_min <= '1;
                for (int s = 0; s < LS; s++) begin
                  valid[s] <= '0;
                end
                state <= ST_FINISH;
              end
              ACT_LOAD: begin
                for (int s = 0; s < LS; s++) begin
                  for (int e = 0; e < LE; e++) begin
                    if (load_ok && req.stage == STAGE_W'(s) &&
                        req.entry_slot == SLOT_W'(e)) begin
                      valid[s][e] <= 1'b1;
                    end
                  end
                end
                state <= ST_FINISH;
              end
              ACT_XLATE: begin
                state <= ST_SCAN;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (stage_done) begin
            // Flush the read pipe and restart at slot 0 of the next stage, or finish after the last.
            rd_slot  <= '0;
            rd_live  <= 1'b1;
            cmp_live <= 1'b0;
            if (last_stage) begin
              state <= ST_FINISH;
            end else begin
              st <= st + ST_W'(1);
            end
          end else begin
            cmp_live <= rd_live;
            cmp_slot <= rd_slot;
            if (rd_live) begin
              if (rd_slot == SL_W'(LE - 1)) begin
                rd_live <= 1'b0;
              end else begin
                rd_slot <= rd_slot + SL_W'(1);
              end
            end
          end
        end

        ST_FINISH: begin
          // Hold here until the output register can take the beat.
          if (rsp_free) begin
            if (new_min) begin
              running_min <= cur;
            end
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      cur <= req.query_value;
    end else if ((state == ST_SCAN) && !xlate_done) begin
      if (!stage_any) begin
        cur <= '0;
      end else if (hit) begin
        cur <= cur + rd_word.delta;
      end
    end else if (xlate_done) begin
      if (!stage_any) begin
        cur <= '0;
      end else if (hit) begin
        cur <= cur + rd_word.delta;
      end
    end

    if ((state == ST_FINISH) && rsp_free) begin
      rsp.mapped_value  <= fin_mapped;
      rsp.lowest_so_far <= new_min ? cur : running_min;
      rsp.done_res      <= 1'b1;
    end
  end

endmodule

// ----- bench/cascaded_range_remap_min_core_tb.sv -----
`timescale 1ns / 1ps

module cascaded_range_remap_min_core_tb;
  import crrm_pkg::*;

  localparam int NUM_STAGES = 7;
  localparam int ENTRIES = 32;
  localparam int ITEMS = 1550;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 240;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [VALUE_W-1:0] MAXV = {VALUE_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  req_t req = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall = 1'b0;

  cascaded_range_remap_min_core #(
    .NUM_STAGES(NUM_STAGES),
    .ENTRIES_PER_STAGE(ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp(rsp),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall)
  );

  always #5 clk = ~clk;

  // Commands waiting to be offered, and response beats still owed by the block.
  req_t pend_q[$];
  rsp_t expected_rsp_q[$];

  // Shadow copy of the remap tables and the running minimum.
  logic [VALUE_W-1:0] rt_dest [NUM_STAGES][ENTRIES];
  logic [VALUE_W-1:0] rt_src [NUM_STAGES][ENTRIES];
  logic [VALUE_W-1:0] rt_len [NUM_STAGES][ENTRIES];
  logic rt_vld [NUM_STAGES][ENTRIES];
  logic [VALUE_W-1:0] low_mark;

  int unsigned acc_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  int unsigned hold_rounds = 0;
  int useful = 0;
  int n_checked = 0;
  int fail_cnt = 0;
  int n_xlate = 0;
  int n_load = 0;
  int n_dropped = 0;
  int n_clear = 0;
  int n_nop = 0;

  // Idle mix rotates every 150 accepted commands: none, sender idle,
  // receiver stall, then both lightly.
  int unsigned idle_phase;
  int unsigned send_idle_pct;
  int unsigned rcv_stall_pct;
  assign idle_phase = (acc_cnt / 150) % 4;
  assign send_idle_pct = (idle_phase == 1) ? 76 : (idle_phase == 3) ? 20 : 0;
  assign rcv_stall_pct = (idle_phase == 2) ? 76 : (idle_phase == 3) ? 20 : 0;

  function automatic logic [VALUE_W-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[VALUE_W-1:0];
  endfunction

  // Fill every field at random; callers then fix the fields that matter.
  function automatic req_t rand_req();
    req_t r;
    r.action = action_t'($urandom_range(0, 3));
    r.stage = STAGE_W'($urandom_range(0, (1 << STAGE_W) - 1));
    r.entry_slot = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
    r.dest_start = rand_word();
    r.src_start = rand_word();
    r.range_length = rand_word();
    r.query_value = rand_word();
    return r;
  endfunction

  function automatic req_t cmd(action_t a, int st, int sl, logic [VALUE_W-1:0] d,
                               logic [VALUE_W-1:0] s, logic [VALUE_W-1:0] l,
                               logic [VALUE_W-1:0] q);
    req_t r;
    r.action = a;
    r.stage = STAGE_W'(st);
    r.entry_slot = SLOT_W'(sl);
    r.dest_start = d;
    r.src_start = s;
    r.range_length = l;
    r.query_value = q;
    return r;
  endfunction

  // Queue one command; beats the block only ignores do not count as work.
  function automatic void queue_item(req_t r);
    pend_q.insert(pend_q.size(), r);
    if (r.action != ACT_NOP && !(r.action == ACT_LOAD && int'(r.stage) >= NUM_STAGES))
      useful++;
  endfunction

  // One stage of the cascade: lowest valid slot whose source range holds v wins.
  function automatic logic [VALUE_W-1:0] walk_stage(int s, logic [VALUE_W-1:0] v);
    logic any_valid;
    any_valid = 1'b0;
    for (int e = 0; e < ENTRIES; e++) begin
      if (rt_vld[s][e]) begin
        any_valid = 1'b1;
        // Upper bound is exclusive; v - src cannot wrap once v >= src.
        if (v >= rt_src[s][e] && (v - rt_src[s][e]) < rt_len[s][e])
          return rt_dest[s][e] + (v - rt_src[s][e]);
      end
    end
    // Empty stage collapses to zero; otherwise the value passes unchanged.
    return any_valid ? v : '0;
  endfunction

  // Advance the shadow state by one accepted command and queue its response.
  function automatic void apply_command(req_t r);
    rsp_t want;
    logic [VALUE_W-1:0] v;
    want = '0;
    want.done_res = 1'b1;
    case (r.action)
      ACT_CLEAR: begin
        for (int s = 0; s < NUM_STAGES; s++)
          for (int e = 0; e < ENTRIES; e++)
            rt_vld[s][e] = 1'b0;
        low_mark = MAXV;
        n_clear++;
      end
      ACT_LOAD: begin
        n_load++;
        if (int'(r.stage) < NUM_STAGES && int'(r.entry_slot) < ENTRIES) begin
          rt_dest[r.stage][r.entry_slot] = r.dest_start;
          rt_src[r.stage][r.entry_slot] = r.src_start;
          rt_len[r.stage][r.entry_slot] = r.range_length;
          rt_vld[r.stage][r.entry_slot] = 1'b1;
        end else begin
          n_dropped++;
        end
      end
      ACT_XLATE: begin
        v = r.query_value;
        for (int s = 0; s < NUM_STAGES; s++)
          v = walk_stage(s, v);
        if (v < low_mark)
          low_mark = v;
        want.mapped_value = v;
        n_xlate++;
      end
      default: begin
        n_nop++;
      end
    endcase
    want.lowest_so_far = low_mark;
    expected_rsp_q.insert(expected_rsp_q.size(), want);
  endfunction

  task automatic flag_mismatch(string what, logic [VALUE_W-1:0] got,
                               logic [VALUE_W-1:0] want_v);
    if (fail_cnt < 200)
      $display("MISMATCH beat %0d: %s got %h want %h", n_checked, what, got, want_v);
    fail_cnt++;
  endtask

  // Driver: predict each accepted beat, then offer the next one or go idle.
  // Hold valid and payload while the block stalls.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        apply_command(req);
        acc_cnt <= acc_cnt + 1;
      end
      if (!req_valid || !req_stall) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req <= pend_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, twice in the run, so the block backs up and stalls
  // its request side while the driver keeps offering.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (hold_rounds < 2 && acc_cnt >= 400 + 700 * hold_rounds) begin
        hold_left <= HOLD_CYCLES;
        hold_rounds <= hold_rounds + 1;
      end
    end
  end

  // Monitor: check each accepted response beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          flag_mismatch("unexpected beat, mapped_value", rsp.mapped_value, '0);
        end else begin
          if (rsp.mapped_value !== expected_rsp_q[0].mapped_value)
            flag_mismatch("mapped_value", rsp.mapped_value,
                          expected_rsp_q[0].mapped_value);
          if (rsp.lowest_so_far !== expected_rsp_q[0].lowest_so_far)
            flag_mismatch("lowest_so_far", rsp.lowest_so_far,
                          expected_rsp_q[0].lowest_so_far);
          if (rsp.done_res !== expected_rsp_q[0].done_res)
            flag_mismatch("done_res", VALUE_W'(rsp.done_res),
                          VALUE_W'(expected_rsp_q[0].done_res));
          void'(expected_rsp_q.pop_front());
        end
        n_checked++;
      end
      rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
               expected_rsp_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    req_t r;
    logic [VALUE_W-1:0] base;
    int n;

    for (int s = 0; s < NUM_STAGES; s++)
      for (int e = 0; e < ENTRIES; e++)
        rt_vld[s][e] = 1'b0;
    low_mark = MAXV;

    // Directed part. Stages 1-6 get an identity entry in the top slot so that
    // stage 0 alone decides the result.
    queue_item(cmd(ACT_CLEAR, 0, 0, '0, '0, '0, '0));
    // Load aimed past the last stage: must change nothing.
    queue_item(cmd(ACT_LOAD, NUM_STAGES, ENTRIES - 1, MAXV, MAXV, MAXV, MAXV));
    for (int s = 1; s < NUM_STAGES; s++)
      queue_item(cmd(ACT_LOAD, s, ENTRIES - 1, '0, '0, MAXV, '0));
    // Zero-length entry never matches.
    queue_item(cmd(ACT_LOAD, 0, 0, 48'd7, 48'd100, '0, '0));
    // Destination at the top: dest + offset wraps.
    queue_item(cmd(ACT_LOAD, 0, 2, MAXV, '0, 48'd50, '0));
    queue_item(cmd(ACT_LOAD, 0, 5, 48'd1000, 48'd100, 48'd10, '0));
    // Source range running past the top of the value space still matches.
    queue_item(cmd(ACT_LOAD, 0, 7, 48'h123, MAXV - 48'd9, MAXV, '0));
    // Same range in a higher slot: shadowed by slot 5.
    queue_item(cmd(ACT_LOAD, 0, 9, 48'd5, 48'd100, 48'd10, '0));
    queue_item(cmd(ACT_XLATE, 0, 0, '0, '0, '0, 48'd105));
    // Overwrite slot 5.
    queue_item(cmd(ACT_LOAD, 0, 5, 48'd2000, 48'd100, 48'd10, '0));
    queue_item(cmd(ACT_XLATE, 0, 0, '0, '0, '0, 48'd105));
    queue_item(cmd(ACT_XLATE, 0, 0, '0, '0, '0, 48'd109));
    // Exclusive upper bound: 110 falls outside [100, 110).
    queue_item(cmd(ACT_XLATE, 0, 0, '0, '0, '0, 48'd110));
    queue_item(cmd(ACT_XLATE, 0, 0, '0, '0, '0, 48'd5));
    queue_item(cmd(ACT_XLATE, 0, 0, '0, '0, '0, MAXV));
    queue_item(cmd(ACT_XLATE, 0, 0, '0, '0, '0, '0));
    queue_item(cmd(ACT_NOP, 0, 0, MAXV, MAXV, MAXV, MAXV));
    queue_item(cmd(ACT_CLEAR, 0, 0, '0, '0, '0, '0));
    // All stages empty: any value collapses to zero.
    queue_item(cmd(ACT_XLATE, 0, 0, '0, '0, '0, MAXV));

    // Random part: mostly well-formed table builds followed by lookups around
    // one base value, mixed with fully random noise beats.
    while (useful < ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_item(rand_req());
      end else begin
        case ($urandom_range(0, 3))
          0, 1: base = VALUE_W'($urandom_range(0, 65535));
          2: base = rand_word();
          default: base = MAXV - VALUE_W'($urandom_range(0, 8191));
        endcase
        if ($urandom_range(0, 9) != 0) begin
          r = rand_req();
          r.action = ACT_CLEAR;
          queue_item(r);
        end
        for (int s = 0; s < NUM_STAGES; s++) begin
          // Leave a stage empty now and then.
          if ($urandom_range(0, 24) == 0)
            continue;
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, ENTRIES) : $urandom_range(1, 4);
          repeat (n) begin
            r = rand_req();
            r.action = ACT_LOAD;
            r.stage = STAGE_W'(s);
            r.entry_slot = SLOT_W'($urandom_range(0, ENTRIES - 1));
            r.src_start = base + VALUE_W'($urandom_range(0, 4095));
            case ($urandom_range(0, 9))
              8: r.dest_start = rand_word();
              9: r.dest_start = MAXV - VALUE_W'($urandom_range(0, 4095));
              default: r.dest_start = base + VALUE_W'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 9))
              0: r.range_length = '0;
              1: r.range_length = rand_word();
              2: r.range_length = MAXV;
              default: r.range_length = VALUE_W'($urandom_range(1, 2048));
            endcase
            queue_item(r);
          end
        end
        repeat ($urandom_range(3, 12)) begin
          r = rand_req();
          r.action = ACT_XLATE;
          case ($urandom_range(0, 9))
            8: r.query_value = rand_word();
            9: r.query_value = $urandom_range(0, 1) ? MAXV : '0;
            default: r.query_value = base + VALUE_W'($urandom_range(0, 6143));
          endcase
          queue_item(r);
        end
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for every beat to go in, every response to come back, then drain.
    while (pend_q.size() != 0 || req_valid) @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d translates, %0d loads (%0d past the last stage), %0d clears, %0d no-ops",
             n_xlate, n_load, n_dropped, n_clear, n_nop);
    $display("Checked %0d response beats over four idle mixes and %0d long hold-offs",
             n_checked, hold_rounds);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/crrm_pkg.sv
sv/cascaded_range_remap_min_core.sv
bench/cascaded_range_remap_min_core_tb.sv
